// File: sv/pvi_pkg.sv
// Types, constants and a saturation helper shared by the variable-interval PID block.
package pvi_pkg;

    localparam int DATA_W    = 32;
    localparam int LIMIT_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W     = DATA_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int OPA_W     = DATA_W + 1;
    localparam int PROD_W    = OPA_W + DATA_W;
    localparam int WIDE_W    = PROD_W + 1;
    localparam int Q_SHIFT   = 16;

    localparam logic signed [WIDE_W-1:0] SAT_HI =
        {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_LO =
        {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_INTERVAL_LIMIT = 3'd4,
        REG_DERIV_MODE     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MUL_ERR_IVL,
        MUL_T_GI,
        MUL_ERR_GP,
        MUL_Q_GD
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIFF,
        ST_MUL_T,
        ST_SAT_T,
        ST_MUL_I,
        ST_INC,
        ST_ACC,
        ST_CLAMP,
        ST_MUL_P,
        ST_P,
        ST_WAIT_DIV,
        ST_MUL_D,
        ST_D,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic     load;
        logic     prep;
        logic     diff;
        logic     div_start;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     t_en;
        logic     inc_en;
        logic     acc_en;
        logic     clamp_en;
        logic     p_en;
        logic     q_en;
        logic     d_en;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } status_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: sv/pvi_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module pvi_div
    import pvi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic [DIV_W-1:0]  quotient
);

    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DATA_W-1:0]    den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [DIV_W-1:0]     shifted;
    logic [DIV_W-1:0]     trial;
    logic                 fits;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        trial    = shifted - {1'b0, den_reg};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/pvi_dp.sv
// Datapath: config registers, loop state, shared multiplier, divider and output register.
module pvi_dp
    import pvi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic signed [DATA_W-1:0] s_target,
    input  logic signed [DATA_W-1:0] s_measured,
    input  logic [DATA_W-1:0]    s_now,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [DATA_W-1:0] m_control,
    output logic                 m_zero_interval
);

    // configuration
    logic signed [DATA_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIMIT_W-1:0]       int_limit_reg;
    logic [DATA_W-1:0]        ivl_limit_reg;
    logic                     mode_reg;

    // loop state
    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] prev_value_reg;
    logic [DATA_W-1:0]        prev_time_reg;

    // working registers
    logic signed [DATA_W-1:0] tgt_reg, meas_reg;
    logic [DATA_W-1:0]        now_reg;
    logic [DATA_W-1:0]        ivl_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DIV_W-1:0]  diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] t_reg, inc_reg, p_reg, q_reg, d_reg;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_control_reg;
    logic                     m_zero_reg;

    logic signed [OPA_W-1:0]  mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [DATA_W-1:0] scaled;
    logic signed [DATA_W-1:0] diff_src;
    logic [DIV_W-1:0]         div_dividend;
    logic [DIV_W-1:0]         div_quo;
    logic                     div_busy;
    logic                     zero_ivl;
    logic signed [DIV_W-1:0]  acc_ext;
    logic [DIV_W-1:0]         acc_mag;
    logic signed [DATA_W-1:0] limit_s;
    logic signed [WIDE_W-1:0] quo_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            int_limit_reg <= '1;
            ivl_limit_reg <= '1;
            mode_reg      <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GAIN_P:         gain_p_reg    <= cfg_data;
                REG_GAIN_I:         gain_i_reg    <= cfg_data;
                REG_GAIN_D:         gain_d_reg    <= cfg_data;
                REG_INTEGRAL_LIMIT: int_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_INTERVAL_LIMIT: ivl_limit_reg <= cfg_data;
                REG_DERIV_MODE:     mode_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        zero_ivl     = (ivl_reg == '0);
        diff_src     = mode_reg ? meas_reg : err_reg;
        div_dividend = diff_reg[DIV_W-1] ? DIV_W'(-diff_reg) : DIV_W'(diff_reg);
        scaled       = sat32(WIDE_W'(prod_reg >>> Q_SHIFT));
        acc_ext      = DIV_W'(acc_reg);
        acc_mag      = acc_reg[DATA_W-1] ? DIV_W'(-acc_ext) : DIV_W'(acc_ext);
        limit_s      = $signed({1'b0, int_limit_reg});
        quo_ext      = $signed(WIDE_W'(div_quo));
        case (cmd.mul_sel)
            MUL_ERR_IVL: begin
                mul_a = $signed({1'b0, ivl_reg});
                mul_b = err_reg;
            end
            MUL_T_GI: begin
                mul_a = OPA_W'(t_reg);
                mul_b = gain_i_reg;
            end
            MUL_ERR_GP: begin
                mul_a = OPA_W'(err_reg);
                mul_b = gain_p_reg;
            end
            MUL_Q_GD: begin
                mul_a = OPA_W'(q_reg);
                mul_b = gain_d_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pvi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (ivl_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // loop state: integral and previous sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg        <= '0;
            prev_value_reg <= '0;
            prev_time_reg  <= '0;
        end else begin
            if (cmd.diff) begin
                prev_value_reg <= diff_src;
                prev_time_reg  <= now_reg;
            end
            if (cmd.acc_en && (ivl_reg <= ivl_limit_reg)) begin
                acc_reg <= sat32(WIDE_W'(acc_reg) + WIDE_W'(inc_reg));
            end
            if (cmd.clamp_en && (acc_mag >= DIV_W'(int_limit_reg))) begin
                acc_reg <= (acc_reg > 0) ? limit_s : -limit_s;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tgt_reg  <= s_target;
            meas_reg <= s_measured;
            now_reg  <= s_now;
        end
        if (cmd.prep) begin
            ivl_reg <= now_reg - prev_time_reg;
            err_reg <= sat32(WIDE_W'(tgt_reg) - WIDE_W'(meas_reg));
        end
        if (cmd.diff) begin
            diff_reg <= DIV_W'(diff_src) - DIV_W'(prev_value_reg);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.t_en) begin
            t_reg <= sat32(WIDE_W'(prod_reg));
        end
        if (cmd.inc_en) begin
            inc_reg <= scaled;
        end
        if (cmd.p_en) begin
            p_reg <= scaled;
        end
        if (cmd.q_en) begin
            q_reg <= sat32(diff_reg[DIV_W-1] ? -quo_ext : quo_ext);
        end
        if (cmd.d_en) begin
            d_reg <= zero_ivl ? '0 : scaled;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_control_reg <= sat32(WIDE_W'(p_reg) + WIDE_W'(acc_reg) + WIDE_W'(d_reg));
            m_zero_reg    <= zero_ivl;
        end
    end

    assign status.div_done = !div_busy;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_control       = m_control_reg;
    assign m_zero_interval = m_zero_reg;

endmodule

// File: sv/pvi_ctrl.sv
// Controller: sequences one sample through the datapath.
module pvi_ctrl
    import pvi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_PREP;
            ST_PREP:     state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_MUL_T;
            ST_MUL_T:    state_next = ST_SAT_T;
            ST_SAT_T:    state_next = ST_MUL_I;
            ST_MUL_I:    state_next = ST_INC;
            ST_INC:      state_next = ST_ACC;
            ST_ACC:      state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_MUL_P;
            ST_MUL_P:    state_next = ST_P;
            ST_P:        state_next = ST_WAIT_DIV;
            ST_WAIT_DIV: if (status.div_done) state_next = ST_MUL_D;
            ST_MUL_D:    state_next = ST_D;
            ST_D:        state_next = ST_SUM;
            ST_SUM:      if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_PREP:  cmd.prep = 1'b1;
            ST_DIFF:  cmd.diff = 1'b1;
            ST_MUL_T: begin
                cmd.div_start = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_ERR_IVL;
            end
            ST_SAT_T: cmd.t_en = 1'b1;
            ST_MUL_I: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_T_GI;
            end
            ST_INC:   cmd.inc_en = 1'b1;
            ST_ACC:   cmd.acc_en = 1'b1;
            ST_CLAMP: cmd.clamp_en = 1'b1;
            ST_MUL_P: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ERR_GP;
            end
            ST_P:        cmd.p_en = 1'b1;
            ST_WAIT_DIV: cmd.q_en = status.div_done;
            ST_MUL_D: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Q_GD;
            end
            ST_D:     cmd.d_en = 1'b1;
            ST_SUM:   cmd.out_load = status.out_free;
            default: ;
        endcase
    end

endmodule

// File: sv/pid_variable_interval.sv
// Top level of the variable-interval PID controller.
//
// Input beat (s_valid/s_ready): setpoint s_target, measurement s_measured and
// timestamp s_now in ticks, all Q16.16 where signed. Each input beat yields
// exactly one output beat (m_valid/m_ready): m_control = sat(p + i + d) and
// m_zero_interval, set when the tick distance to the previous beat was zero.
// Gains and limits are written over cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high. Write them only while no sample is in flight.
//
// The restoring divider for the derivative quotient runs beside the shared
// 33x32 multiplier, which handles the four products one after another, and
// the controller waits for the divider before it forms the derivative term.
// s_ready is high only while the controller waits for a sample, so one
// sample is in flight at a time.
// The output register lets the next sample be taken while a result waits;
// if the receiver still stalls when that sample is done, the controller
// holds in its final step until the output register frees up.
// Reset (aresetn low, synchronous) clears the integral, previous sample and
// timestamp to zero and restores the register defaults.
module pid_variable_interval
    import pvi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_target,
    input  logic signed [DATA_W-1:0] s_measured,
    input  logic [DATA_W-1:0]        s_now,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_control,
    output logic                     m_zero_interval,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    // commands down, status up; nothing else crosses
    cmd_t    cmd;
    status_t status;

    pvi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pvi_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_target        (s_target),
        .s_measured      (s_measured),
        .s_now           (s_now),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_control       (m_control),
        .m_zero_interval (m_zero_interval)
    );

endmodule

// File: sv/pvi_checker.sv
// Port-level checks for the PID block, bound to the top level.
module pvi_checker
    import pvi_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [DATA_W-1:0] m_control,
    input logic                     m_zero_interval
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_control) && $stable(m_zero_interval))
        else $error("result beat changed while stalled");

    // one sample in flight: no second beat right after the first
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a sample is in flight");

    // a result needs the full sequence, never right after the input beat
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid) ##1 !$rose(m_valid))
        else $error("result appeared too soon after input");

    // reset drops the result and reopens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the handshake state");

endmodule

bind pid_variable_interval pvi_checker u_pvi_checker (.*);
